@@ rtl/eare_pkg.sv @@
package eare_pkg;

   // Channel stores are sized by the 4-bit channel fields.
   localparam int MAX_INPUTS  = 16;
   localparam int MAX_OUTPUTS = 16;
   localparam int EVENT_BITS  = 3;
   localparam int COUNT_BITS  = 5;

   // Command codes.
   localparam logic [2:0] CMD_SET_EVENT      = 3'd0;
   localparam logic [2:0] CMD_FORCE_OUTPUT   = 3'd1;
   localparam logic [2:0] CMD_REQ_LOCAL_OFF  = 3'd2;
   localparam logic [2:0] CMD_REQ_GLOBAL_OFF = 3'd3;
   localparam logic [2:0] CMD_EXECUTE        = 3'd4;
   localparam logic [2:0] CMD_ADD_RULE       = 3'd5;
   localparam logic [2:0] CMD_CLEAR_RULES    = 3'd6;
   localparam logic [2:0] CMD_READ_OUTPUT    = 3'd7;

   // Rule actions.
   localparam logic [2:0] ACT_NONE       = 3'd0;
   localparam logic [2:0] ACT_LOCAL_OFF  = 3'd1;
   localparam logic [2:0] ACT_GLOBAL_OFF = 3'd2;
   localparam logic [2:0] ACT_TURN_ON    = 3'd3;
   localparam logic [2:0] ACT_TURN_OFF   = 3'd4;
   localparam logic [2:0] ACT_TOGGLE     = 3'd5;

   // Output states.
   localparam logic [1:0] ST_UNKNOWN = 2'd0;
   localparam logic [1:0] ST_OFF     = 2'd1;
   localparam logic [1:0] ST_ON      = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   // Status codes.
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_BAD_CHANNEL = 2'd1;
   localparam logic [1:0] STAT_TABLE_FULL  = 2'd2;

   // Register indexes.
   localparam logic REG_INPUT_COUNT  = 1'b0;
   localparam logic REG_OUTPUT_COUNT = 1'b1;

   typedef struct packed {
      logic [3:0]            in_ch;
      logic [EVENT_BITS-1:0] ev;
      logic [2:0]            act;
      logic [3:0]            out_ch;
   } rule_type;

   typedef struct packed {
      logic accept_simple;
      logic exec_begin;
      logic rule_issue;
      logic rule_apply;
      logic exec_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rules_left;
   } dp_status_type;

endpackage

@@ rtl/eare_ctrl.sv @@
module eare_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0]             req_cmd,
   input  eare_pkg::dp_status_type dp_status,
   output eare_pkg::ctrl_cmd_type ctrl_cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_RULES  = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      apply_ff, apply_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      apply_in     = 1'b0;
      rsp_valid_in = 1'b0;
      ctrl_cmd     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == eare_pkg::CMD_EXECUTE) begin
                  ctrl_cmd.exec_begin = 1'b1;
                  state_in = S_RULES;
               end else begin
                  ctrl_cmd.accept_simple = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_RULES: begin
            // Read of rule i overlaps the apply of rule i-1.
            ctrl_cmd.rule_issue = dp_status.rules_left;
            ctrl_cmd.rule_apply = apply_ff;
            apply_in = dp_status.rules_left;
            if (!dp_status.rules_left && !apply_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            ctrl_cmd.exec_finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         apply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         apply_ff     <= apply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/eare_datapath.sv @@
module eare_datapath #(
   parameter int MAX_RULES = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  eare_pkg::ctrl_cmd_type  ctrl_cmd,
   output eare_pkg::dp_status_type dp_status,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [4:0]              csr_wdata,
   input  logic [2:0]              req_cmd,
   input  logic [3:0]              req_channel,
   input  logic [2:0]              req_event_code,
   input  logic [1:0]              req_force_state,
   input  logic [2:0]              req_rule_action,
   input  logic [3:0]              req_rule_output,
   output logic [1:0]              rsp_status,
   output logic [1:0]              rsp_output_state,
   output logic                    rsp_local_off_done,
   output logic                    rsp_global_off_done
);

   localparam int CW = $clog2(MAX_RULES + 1);
   localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int NI = eare_pkg::MAX_INPUTS;
   localparam int NO = eare_pkg::MAX_OUTPUTS;
   localparam int EB = eare_pkg::EVENT_BITS;
   localparam int KB = eare_pkg::COUNT_BITS;

   logic [EB-1:0] events_ff [NI];
   logic [EB-1:0] events_in [NI];
   logic [1:0]    forced_ff [NO];
   logic [1:0]    forced_in [NO];
   logic [1:0]    states_ff [NO];
   logic [1:0]    states_in [NO];
   logic [KB-1:0] in_count_ff, in_count_in;
   logic [KB-1:0] out_count_ff, out_count_in;
   logic [CW-1:0] rule_count_ff, rule_count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          lreq_ff, lreq_in, greq_ff, greq_in;
   logic          lflag_ff, lflag_in, gflag_ff, gflag_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [1:0]    rsp_state_ff, rsp_state_in;

   eare_pkg::rule_type rule_mem [MAX_RULES];
   eare_pkg::rule_type rd_data_ff;
   eare_pkg::rule_type new_rule;
   logic               rule_wr;
   logic               rule_hit;
   logic [1:0]         cur_state;
   logic               ch_in_ok, ch_out_ok;

   assign new_rule = '{in_ch: req_channel, ev: req_event_code[EB-1:0],
                       act: req_rule_action, out_ch: req_rule_output};
   assign rule_wr  = ctrl_cmd.accept_simple && (req_cmd == eare_pkg::CMD_ADD_RULE)
                     && (rule_count_ff < CW'(MAX_RULES));
   assign ch_in_ok  = ({1'b0, req_channel} < in_count_ff);
   assign ch_out_ok = ({1'b0, req_channel} < out_count_ff);

   assign rule_hit  = (rd_data_ff.ev != '0)
                      && ({1'b0, rd_data_ff.in_ch} < in_count_ff)
                      && (events_ff[rd_data_ff.in_ch] == rd_data_ff.ev);
   assign cur_state = states_ff[rd_data_ff.out_ch];

   assign dp_status.rules_left = (idx_ff < rule_count_ff);

   always_comb begin
      events_in     = events_ff;
      forced_in     = forced_ff;
      states_in     = states_ff;
      in_count_in   = in_count_ff;
      out_count_in  = out_count_ff;
      rule_count_in = rule_count_ff;
      idx_in        = idx_ff;
      lreq_in       = lreq_ff;
      greq_in       = greq_ff;
      lflag_in      = lflag_ff;
      gflag_in      = gflag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_state_in  = rsp_state_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            eare_pkg::REG_INPUT_COUNT: begin
               if (csr_wdata <= KB'(NI)) begin
                  in_count_in = csr_wdata;
                  for (int i = 0; i < NI; i++) events_in[i] = '0;
               end
            end
            eare_pkg::REG_OUTPUT_COUNT: begin
               if (csr_wdata <= KB'(NO)) begin
                  out_count_in = csr_wdata;
                  lreq_in = 1'b0;
                  greq_in = 1'b0;
                  for (int i = 0; i < NO; i++) begin
                     forced_in[i] = eare_pkg::ST_UNKNOWN;
                     if (KB'(i) >= csr_wdata) states_in[i] = eare_pkg::ST_UNKNOWN;
                  end
               end
            end
            default: ;
         endcase
      end

      if (ctrl_cmd.accept_simple) begin
         rsp_status_in = eare_pkg::STAT_OK;
         rsp_state_in  = eare_pkg::ST_UNKNOWN;
         unique case (req_cmd)
            eare_pkg::CMD_SET_EVENT: begin
               if (!ch_in_ok) rsp_status_in = eare_pkg::STAT_BAD_CHANNEL;
               else events_in[req_channel] = req_event_code[EB-1:0];
            end
            eare_pkg::CMD_FORCE_OUTPUT: begin
               if (!ch_out_ok) rsp_status_in = eare_pkg::STAT_BAD_CHANNEL;
               else if (req_force_state == eare_pkg::ST_INVALID)
                  forced_in[req_channel] = eare_pkg::ST_UNKNOWN;
               else forced_in[req_channel] = req_force_state;
            end
            eare_pkg::CMD_REQ_LOCAL_OFF:  lreq_in = 1'b1;
            eare_pkg::CMD_REQ_GLOBAL_OFF: greq_in = 1'b1;
            eare_pkg::CMD_EXECUTE: ;
            eare_pkg::CMD_ADD_RULE: begin
               if (!rule_wr) rsp_status_in = eare_pkg::STAT_TABLE_FULL;
               else rule_count_in = CW'(rule_count_ff + 1'b1);
            end
            eare_pkg::CMD_CLEAR_RULES: rule_count_in = '0;
            eare_pkg::CMD_READ_OUTPUT: begin
               if (!ch_out_ok) rsp_status_in = eare_pkg::STAT_BAD_CHANNEL;
               else rsp_state_in = states_ff[req_channel];
            end
            default: ;
         endcase
      end

      if (ctrl_cmd.exec_begin) begin
         lflag_in = 1'b0;
         gflag_in = 1'b0;
         idx_in   = '0;
      end

      if (ctrl_cmd.rule_issue) begin
         idx_in = CW'(idx_ff + 1'b1);
      end

      if (ctrl_cmd.rule_apply && rule_hit) begin
         unique case (rd_data_ff.act)
            eare_pkg::ACT_LOCAL_OFF, eare_pkg::ACT_GLOBAL_OFF: begin
               for (int i = 0; i < NO; i++) begin
                  if (KB'(i) < out_count_ff) states_in[i] = eare_pkg::ST_OFF;
               end
               if (rd_data_ff.act == eare_pkg::ACT_LOCAL_OFF) lflag_in = 1'b1;
               else gflag_in = 1'b1;
            end
            eare_pkg::ACT_TURN_ON, eare_pkg::ACT_TURN_OFF, eare_pkg::ACT_TOGGLE: begin
               if ({1'b0, rd_data_ff.out_ch} < out_count_ff) begin
                  if (rd_data_ff.act == eare_pkg::ACT_TURN_ON)
                     states_in[rd_data_ff.out_ch] = eare_pkg::ST_ON;
                  else if (rd_data_ff.act == eare_pkg::ACT_TURN_OFF)
                     states_in[rd_data_ff.out_ch] = eare_pkg::ST_OFF;
                  else if (cur_state == eare_pkg::ST_OFF)
                     states_in[rd_data_ff.out_ch] = eare_pkg::ST_ON;
                  else
                     states_in[rd_data_ff.out_ch] = eare_pkg::ST_OFF;
               end
            end
            default: ;
         endcase
      end

      if (ctrl_cmd.exec_finish) begin
         // Forces override rule results; pending off requests override both.
         for (int i = 0; i < NO; i++) begin
            if (KB'(i) < out_count_ff) begin
               if (forced_ff[i] != eare_pkg::ST_UNKNOWN) states_in[i] = forced_ff[i];
               if (lreq_ff || greq_ff) states_in[i] = eare_pkg::ST_OFF;
            end
            forced_in[i] = eare_pkg::ST_UNKNOWN;
         end
         for (int i = 0; i < NI; i++) events_in[i] = '0;
         if (lreq_ff) lflag_in = 1'b1;
         if (greq_ff) gflag_in = 1'b1;
         lreq_in       = 1'b0;
         greq_in       = 1'b0;
         rsp_status_in = eare_pkg::STAT_OK;
         rsp_state_in  = eare_pkg::ST_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NI; i++) events_ff[i] <= '0;
         for (int i = 0; i < NO; i++) begin
            forced_ff[i] <= eare_pkg::ST_UNKNOWN;
            states_ff[i] <= eare_pkg::ST_UNKNOWN;
         end
         in_count_ff   <= '0;
         out_count_ff  <= '0;
         rule_count_ff <= '0;
         idx_ff        <= '0;
         lreq_ff       <= 1'b0;
         greq_ff       <= 1'b0;
         lflag_ff      <= 1'b0;
         gflag_ff      <= 1'b0;
      end else begin
         events_ff     <= events_in;
         forced_ff     <= forced_in;
         states_ff     <= states_in;
         in_count_ff   <= in_count_in;
         out_count_ff  <= out_count_in;
         rule_count_ff <= rule_count_in;
         idx_ff        <= idx_in;
         lreq_ff       <= lreq_in;
         greq_ff       <= greq_in;
         lflag_ff      <= lflag_in;
         gflag_ff      <= gflag_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_state_ff  <= rsp_state_in;
   end

   // Rule table: one write port at the fill count, one registered read port.
   always_ff @(posedge clock) begin
      if (rule_wr) rule_mem[rule_count_ff[AW-1:0]] <= new_rule;
      if (ctrl_cmd.rule_issue) rd_data_ff <= rule_mem[idx_ff[AW-1:0]];
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_output_state    = rsp_state_ff;
   assign rsp_local_off_done  = lflag_ff;
   assign rsp_global_off_done = gflag_ff;

endmodule

@@ rtl/event_action_rule_engine_unit.sv @@
// Channel    Ports                                                          Handshake
// request    req_{cmd,channel,event_code,force_state,rule_action,rule_output} start, busy low
// response   rsp_{status,output_state,local_off_done,global_off_done}      rsp_valid, 1 cycle
// registers  csr_index, csr_wdata                                           csr_wr_en, no wait
//
// A command other than execute answers in the cycle after acceptance, when busy is low.
// Execute holds busy through one table read per rule, the apply of the last rule, a
// step that sees the pipe empty, and a finishing step for forces and off requests.
// Its response comes in the cycle that busy drops.
// Reset is synchronous and clears all counts, channel state and flags.
// The receiver cannot stall: each response is shown for exactly one cycle.
module event_action_rule_engine_unit #(
   parameter int MAX_RULES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic [3:0] req_channel,
   input  logic [2:0] req_event_code,
   input  logic [1:0] req_force_state,
   input  logic [2:0] req_rule_action,
   input  logic [3:0] req_rule_output,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_output_state,
   output logic       rsp_local_off_done,
   output logic       rsp_global_off_done,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata
);

   // The controller sequences each transaction; the datapath holds all channel, rule and flag state.
   eare_pkg::ctrl_cmd_type  ctrl_cmd;
   eare_pkg::dp_status_type dp_status;

   eare_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The off-done flags are reported on every response, not only after execute.
   eare_datapath #(
      .MAX_RULES (MAX_RULES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl_cmd            (ctrl_cmd),
      .dp_status           (dp_status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_cmd             (req_cmd),
      .req_channel         (req_channel),
      .req_event_code      (req_event_code),
      .req_force_state     (req_force_state),
      .req_rule_action     (req_rule_action),
      .req_rule_output     (req_rule_output),
      .rsp_status          (rsp_status),
      .rsp_output_state    (rsp_output_state),
      .rsp_local_off_done  (rsp_local_off_done),
      .rsp_global_off_done (rsp_global_off_done)
   );

endmodule

@@ rtl/eare_checker.sv @@
module eare_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_cmd,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [1:0] rsp_output_state
);

   // A non-execute transaction answers in the very next cycle.
   a_simple_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd != eare_pkg::CMD_EXECUTE) |=> rsp_valid)
      else $error("simple command did not respond in one cycle");

   // Execute holds off further commands while the rules run.
   a_exec_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == eare_pkg::CMD_EXECUTE) |=> busy && !rsp_valid)
      else $error("execute did not enter its busy phase");

   // A failed command never reports an output state.
   a_fail_no_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != eare_pkg::STAT_OK) |-> rsp_output_state == eare_pkg::ST_UNKNOWN)
      else $error("output state reported with error status");

   // Table-full status only answers an add_rule transaction.
   a_full_from_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == eare_pkg::STAT_TABLE_FULL)
      |-> $past(req_cmd) == eare_pkg::CMD_ADD_RULE && $past(start) && !$past(busy))
      else $error("table-full status without add_rule");

endmodule

bind event_action_rule_engine_unit eare_checker u_eare_checker (.*);

@@ bench/rule_engine_checker.sv @@
module rule_engine_checker #(
   parameter int RULE_CAPACITY = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [2:0] req_cmd,
   input  logic [3:0] req_channel,
   input  logic [2:0] req_event_code,
   input  logic [1:0] req_force_state,
   input  logic [2:0] req_rule_action,
   input  logic [3:0] req_rule_output,
   input  logic       rsp_valid,
   input  logic [1:0] rsp_status,
   input  logic [1:0] rsp_output_state,
   input  logic       rsp_local_off_done,
   input  logic       rsp_global_off_done,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata,
   output int         failures,
   output int         outstanding
);

   // Replies waiting for the engine; one is the most a correct engine ever leaves open.
   localparam int REPLY_SLOTS = 8;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] state;
      logic       local_off;
      logic       global_off;
   } reply_type;

   logic [eare_pkg::EVENT_BITS-1:0] event_latch [eare_pkg::MAX_INPUTS];
   logic [1:0]                      force_mark  [eare_pkg::MAX_OUTPUTS];
   logic [1:0]                      lamp_state  [eare_pkg::MAX_OUTPUTS];
   eare_pkg::rule_type              rule_store  [RULE_CAPACITY];
   int                              rule_total;
   int                              input_span;
   int                              output_span;
   logic                            local_req, global_req;
   logic                            local_flag, global_flag;

   reply_type reply_slot [REPLY_SLOTS];
   int        slot_head;
   int        slot_tail;
   int        slot_fill;
   reply_type seen_reply;
   reply_type want_reply;
   int        mismatch_count = 0;
   int        n;

   assign failures    = mismatch_count;
   assign outstanding = slot_fill;

   function automatic void clear_events();
      int i;
      for (i = 0; i < eare_pkg::MAX_INPUTS; i++) event_latch[i] = '0;
   endfunction

   function automatic void clear_forces();
      int i;
      local_req  = 1'b0;
      global_req = 1'b0;
      for (i = 0; i < eare_pkg::MAX_OUTPUTS; i++) force_mark[i] = eare_pkg::ST_UNKNOWN;
   endfunction

   function automatic void lamps_off();
      int i;
      for (i = 0; i < output_span; i++) lamp_state[i] = eare_pkg::ST_OFF;
   endfunction

   // Applies one command to the local copy of the engine state and returns its reply.
   function automatic reply_type predict_reply(input logic [2:0] cmd, input logic [3:0] ch,
                                               input logic [2:0] ev, input logic [1:0] fs,
                                               input logic [2:0] act, input logic [3:0] rout);
      reply_type          r;
      eare_pkg::rule_type rl;
      int                 i;
      r = '0;
      case (cmd)
         eare_pkg::CMD_SET_EVENT: begin
            if (ch >= input_span) r.status = eare_pkg::STAT_BAD_CHANNEL;
            else event_latch[ch] = ev;
         end
         eare_pkg::CMD_FORCE_OUTPUT: begin
            if (ch >= output_span) r.status = eare_pkg::STAT_BAD_CHANNEL;
            else force_mark[ch] = (fs == eare_pkg::ST_INVALID) ? eare_pkg::ST_UNKNOWN : fs;
         end
         eare_pkg::CMD_REQ_LOCAL_OFF:  local_req = 1'b1;
         eare_pkg::CMD_REQ_GLOBAL_OFF: global_req = 1'b1;
         eare_pkg::CMD_EXECUTE: begin
            local_flag  = 1'b0;
            global_flag = 1'b0;
            for (i = 0; i < rule_total; i++) begin
               rl = rule_store[i];
               if (rl.ev != '0 && rl.in_ch < input_span && event_latch[rl.in_ch] == rl.ev) begin
                  case (rl.act)
                     eare_pkg::ACT_LOCAL_OFF: begin
                        lamps_off();
                        local_flag = 1'b1;
                     end
                     eare_pkg::ACT_GLOBAL_OFF: begin
                        lamps_off();
                        global_flag = 1'b1;
                     end
                     eare_pkg::ACT_TURN_ON, eare_pkg::ACT_TURN_OFF, eare_pkg::ACT_TOGGLE: begin
                        if (rl.out_ch < output_span) begin
                           if (rl.act == eare_pkg::ACT_TURN_ON)
                              lamp_state[rl.out_ch] = eare_pkg::ST_ON;
                           else if (rl.act == eare_pkg::ACT_TURN_OFF)
                              lamp_state[rl.out_ch] = eare_pkg::ST_OFF;
                           else lamp_state[rl.out_ch] =
                              (lamp_state[rl.out_ch] == eare_pkg::ST_OFF) ?
                              eare_pkg::ST_ON : eare_pkg::ST_OFF;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            for (i = 0; i < output_span; i++)
               if (force_mark[i] != eare_pkg::ST_UNKNOWN) lamp_state[i] = force_mark[i];
            if (local_req) begin
               lamps_off();
               local_flag = 1'b1;
            end
            if (global_req) begin
               lamps_off();
               global_flag = 1'b1;
            end
            clear_forces();
            clear_events();
         end
         eare_pkg::CMD_ADD_RULE: begin
            if (rule_total >= RULE_CAPACITY) r.status = eare_pkg::STAT_TABLE_FULL;
            else begin
               rule_store[rule_total] = '{in_ch: ch, ev: ev, act: act, out_ch: rout};
               rule_total++;
            end
         end
         eare_pkg::CMD_CLEAR_RULES: rule_total = 0;
         eare_pkg::CMD_READ_OUTPUT: begin
            if (ch >= output_span) r.status = eare_pkg::STAT_BAD_CHANNEL;
            else r.state = lamp_state[ch];
         end
         default: ;
      endcase
      r.local_off  = local_flag;
      r.global_off = global_flag;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         slot_head = 0;
         slot_tail = 0;
         slot_fill = 0;
         clear_events();
         clear_forces();
         for (n = 0; n < eare_pkg::MAX_OUTPUTS; n++) lamp_state[n] = eare_pkg::ST_UNKNOWN;
         rule_total  = 0;
         input_span  = 0;
         output_span = 0;
         local_flag  = 1'b0;
         global_flag = 1'b0;
      end else begin
         // The reply of the previous transaction is checked before a new one is queued.
         if (rsp_valid) begin
            seen_reply = '{rsp_status, rsp_output_state, rsp_local_off_done,
                           rsp_global_off_done};
            if (slot_fill == 0) begin
               $display("%0t: reply with nothing expected: status=%0d state=%0d lo=%0d go=%0d",
                        $time, seen_reply.status, seen_reply.state, seen_reply.local_off,
                        seen_reply.global_off);
               mismatch_count++;
            end else begin
               want_reply = reply_slot[slot_head];
               slot_head  = (slot_head + 1) % REPLY_SLOTS;
               slot_fill--;
               if (seen_reply !== want_reply) begin
                  $display("%0t: expected status=%0d state=%0d lo=%0d go=%0d, got status=%0d state=%0d lo=%0d go=%0d",
                           $time, want_reply.status, want_reply.state, want_reply.local_off,
                           want_reply.global_off, seen_reply.status, seen_reply.state,
                           seen_reply.local_off, seen_reply.global_off);
                  mismatch_count++;
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == eare_pkg::REG_INPUT_COUNT) begin
               if (csr_wdata <= eare_pkg::MAX_INPUTS) begin
                  input_span = csr_wdata;
                  clear_events();
               end
            end else if (csr_wdata <= eare_pkg::MAX_OUTPUTS) begin
               output_span = csr_wdata;
               for (n = output_span; n < eare_pkg::MAX_OUTPUTS; n++)
                  lamp_state[n] = eare_pkg::ST_UNKNOWN;
               clear_forces();
            end
         end
         if (start && !busy) begin
            want_reply = predict_reply(req_cmd, req_channel, req_event_code,
                                       req_force_state, req_rule_action, req_rule_output);
            if (slot_fill == REPLY_SLOTS) begin
               $display("%0t: too many transactions without a reply: expected %0d, got %0d",
                        $time, 1, slot_fill + 1);
               mismatch_count++;
            end else begin
               reply_slot[slot_tail] = want_reply;
               slot_tail = (slot_tail + 1) % REPLY_SLOTS;
               slot_fill++;
            end
         end
      end
   end

endmodule

@@ bench/tb_event_action_rule_engine_unit.sv @@
module tb_event_action_rule_engine_unit;

   localparam int RULE_CAPACITY = 32;
   // Longest legal quiet stretch is an execute over a full table plus an idle burst
   // or a drain pause, so this is many times over.
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 400;
   localparam int PHASE_ITEMS   = 80;
   localparam int CALM_TAIL     = 60;

   // Action codes with no package name: they are stored in the table but do nothing.
   localparam logic [2:0] ACT_SPARE_SIX   = 3'd6;
   localparam logic [2:0] ACT_SPARE_SEVEN = 3'd7;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_cmd = '0;
   logic [3:0] req_channel = '0;
   logic [2:0] req_event_code = '0;
   logic [1:0] req_force_state = '0;
   logic [2:0] req_rule_action = '0;
   logic [3:0] req_rule_output = '0;
   logic       rsp_valid;
   logic [1:0] rsp_status;
   logic [1:0] rsp_output_state;
   logic       rsp_local_off_done;
   logic       rsp_global_off_done;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = 1'b0;
   logic [4:0] csr_wdata = '0;

   int failures;
   int outstanding;

   // The bench keeps its own idea of the channel counts only to steer random channels
   // toward the ones in use; prediction lives entirely in the checker.
   int in_span  = 0;
   int out_span = 0;
   int idle_pct = 0;
   int issued   = 0;
   int goal;
   int next_phase;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   event_action_rule_engine_unit #(
      .MAX_RULES(RULE_CAPACITY)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_channel        (req_channel),
      .req_event_code     (req_event_code),
      .req_force_state    (req_force_state),
      .req_rule_action    (req_rule_action),
      .req_rule_output    (req_rule_output),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_output_state   (rsp_output_state),
      .rsp_local_off_done (rsp_local_off_done),
      .rsp_global_off_done(rsp_global_off_done),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   rule_engine_checker #(
      .RULE_CAPACITY(RULE_CAPACITY)
   ) rule_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_channel        (req_channel),
      .req_event_code     (req_event_code),
      .req_force_state    (req_force_state),
      .req_rule_action    (req_rule_action),
      .req_rule_output    (req_rule_output),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_output_state   (rsp_output_state),
      .rsp_local_off_done (rsp_local_off_done),
      .rsp_global_off_done(rsp_global_off_done),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .failures           (failures),
      .outstanding        (outstanding)
   );

   // Sends one command transaction. An optional idle burst comes first, with start
   // low. Inputs change on the falling edge; busy is read right after the rising edge,
   // which still shows the value that the edge sampled. The task returns just after
   // the accepting edge with start still high, so back-to-back transactions never
   // lower and raise start in the same time step.
   task automatic issue(input logic [2:0] cmd, input logic [3:0] ch, input logic [2:0] ev,
                        input logic [1:0] fs, input logic [2:0] act, input logic [3:0] rout);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_cmd         <= cmd;
      req_channel     <= ch;
      req_event_code  <= ev;
      req_force_state <= fs;
      req_rule_action <= act;
      req_rule_output <= rout;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued++;
   endtask

   // Holds the sender off until every reply has come back, so the engine is idle.
   // Every command produces a reply, so a short margin afterwards is plenty.
   task automatic settle();
      @(negedge clock) start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Count registers are written only from an idle engine. Values above sixteen are
   // ignored by the engine, and the steering copy follows the same rule.
   task automatic write_reg(input logic idx, input logic [4:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_wr_en <= 1'b0;
      if (idx == eare_pkg::REG_INPUT_COUNT) begin
         if (val <= eare_pkg::MAX_INPUTS) in_span = val;
      end else if (val <= eare_pkg::MAX_OUTPUTS) begin
         out_span = val;
      end
   endtask

   // Mostly channels in use, so that events latch and rules can fire.
   function automatic logic [3:0] pick_input();
      if (in_span > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, in_span - 1);
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [3:0] pick_output();
      if (out_span > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, out_span - 1);
      return $urandom_range(0, 15);
   endfunction

   // A small pool of event codes makes matches between rules and latched events common.
   function automatic logic [2:0] pick_event();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 7);
      return $urandom_range(1, 3);
   endfunction

   // Counts favor the extremes and include the ignored values above sixteen.
   function automatic logic [4:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 5'd0;
         1:       return 5'd16;
         2:       return $urandom_range(17, 31);
         3:       return 5'd1;
         default: return $urandom_range(2, 16);
      endcase
   endfunction

   // Watchdog: ends the run if no transaction, reply or register write is seen for
   // too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || rsp_valid || (start && !busy)) quiet = 0;
         else quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int adds;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Right after reset both counts are zero, so every channel is out of range.
      issue(eare_pkg::CMD_READ_OUTPUT, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_SET_EVENT, 4'd0, 3'd7, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_FORCE_OUTPUT, 4'd0, 3'd0, eare_pkg::ST_ON, eare_pkg::ACT_NONE, 4'd0);
      settle();
      // Counts above the maximum must be ignored; then open every channel.
      write_reg(eare_pkg::REG_INPUT_COUNT, 5'd31);
      write_reg(eare_pkg::REG_OUTPUT_COUNT, 5'd17);
      write_reg(eare_pkg::REG_INPUT_COUNT, 5'd16);
      write_reg(eare_pkg::REG_OUTPUT_COUNT, 5'd16);

      // Rules at the channel extremes, a toggle of an unknown lamp, the spare action
      // codes, and a rule whose event is none and so never fires.
      issue(eare_pkg::CMD_ADD_RULE, 4'd15, 3'd7, 2'd0, eare_pkg::ACT_TURN_ON, 4'd15);
      issue(eare_pkg::CMD_ADD_RULE, 4'd0, 3'd1, 2'd0, eare_pkg::ACT_TOGGLE, 4'd0);
      issue(eare_pkg::CMD_ADD_RULE, 4'd0, 3'd1, 2'd0, ACT_SPARE_SIX, 4'd1);
      issue(eare_pkg::CMD_ADD_RULE, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_TURN_ON, 4'd1);
      issue(eare_pkg::CMD_ADD_RULE, 4'd1, 3'd2, 2'd0, ACT_SPARE_SEVEN, 4'd2);
      issue(eare_pkg::CMD_SET_EVENT, 4'd15, 3'd7, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_SET_EVENT, 4'd0, 3'd1, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_SET_EVENT, 4'd1, 3'd2, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      // A real force, and force state three, which only clears the mark.
      issue(eare_pkg::CMD_FORCE_OUTPUT, 4'd3, 3'd0, eare_pkg::ST_ON, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_FORCE_OUTPUT, 4'd4, 3'd0, eare_pkg::ST_INVALID, eare_pkg::ACT_NONE,
            4'd0);
      issue(eare_pkg::CMD_EXECUTE, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_READ_OUTPUT, 4'd15, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_READ_OUTPUT, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_READ_OUTPUT, 4'd3, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      // Off actions from rules, and both off requests in one execute.
      issue(eare_pkg::CMD_ADD_RULE, 4'd2, 3'd5, 2'd0, eare_pkg::ACT_LOCAL_OFF, 4'd0);
      issue(eare_pkg::CMD_ADD_RULE, 4'd3, 3'd6, 2'd0, eare_pkg::ACT_GLOBAL_OFF, 4'd0);
      issue(eare_pkg::CMD_SET_EVENT, 4'd2, 3'd5, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_SET_EVENT, 4'd3, 3'd6, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_REQ_LOCAL_OFF, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_REQ_GLOBAL_OFF, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_EXECUTE, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_READ_OUTPUT, 4'd15, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      settle();
      // With fewer outputs the first rule now targets a lamp out of range.
      write_reg(eare_pkg::REG_OUTPUT_COUNT, 5'd4);
      issue(eare_pkg::CMD_SET_EVENT, 4'd15, 3'd7, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_EXECUTE, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_READ_OUTPUT, 4'd15, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);
      issue(eare_pkg::CMD_CLEAR_RULES, 4'd0, 3'd0, 2'd0, eare_pkg::ACT_NONE, 4'd0);

      // Random part. Each round is a well-formed sequence: maybe clear the table, add
      // rules, latch events, force lamps, maybe request an off, execute, then read
      // back. Now and then a round fills the table past its capacity, and a fully
      // random transaction is mixed in as noise. Counts change between phases.
      goal       = issued + RANDOM_ITEMS;
      next_phase = issued;
      while (issued < goal) begin
         if (issued >= next_phase) begin
            settle();
            write_reg(eare_pkg::REG_INPUT_COUNT, pick_count());
            write_reg(eare_pkg::REG_OUTPUT_COUNT, pick_count());
            next_phase = issued + PHASE_ITEMS;
            idle_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
         end
         if (issued >= goal - CALM_TAIL) idle_pct = 0;

         if ($urandom_range(0, 4) == 0)
            issue(eare_pkg::CMD_CLEAR_RULES, $urandom, $urandom, $urandom, $urandom, $urandom);
         adds = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
         repeat (adds)
            issue(eare_pkg::CMD_ADD_RULE, pick_input(), pick_event(), $urandom,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(3, 5),
                  pick_output());
         repeat ($urandom_range(1, 4))
            issue(eare_pkg::CMD_SET_EVENT, pick_input(), pick_event(), $urandom, $urandom,
                  $urandom);
         repeat ($urandom_range(0, 2))
            issue(eare_pkg::CMD_FORCE_OUTPUT, pick_output(), $urandom, $urandom_range(0, 3),
                  $urandom, $urandom);
         if ($urandom_range(0, 5) == 0)
            issue(eare_pkg::CMD_REQ_LOCAL_OFF, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
         if ($urandom_range(0, 5) == 0)
            issue(eare_pkg::CMD_REQ_GLOBAL_OFF, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
         if ($urandom_range(0, 3) == 0)
            issue($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         issue(eare_pkg::CMD_EXECUTE, $urandom, $urandom, $urandom, $urandom, $urandom);
         repeat ($urandom_range(1, 4))
            issue(eare_pkg::CMD_READ_OUTPUT, pick_output(), $urandom, $urandom, $urandom,
                  $urandom);
      end

      // Drain every reply, then give a full-table execute's worth of extra cycles so
      // that a stray late reply would still be caught.
      settle();
      repeat (RULE_CAPACITY + 8) @(posedge clock);
      if (failures == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
